### rtl/wfhv_pkg.sv
// ----------------------------------------------------------------------------
// wfhv_pkg: shared definitions of the frame header validator
// Widths, codes, the per-frame record that the capture side hands to the
// checking side, and the queue status group.
// ----------------------------------------------------------------------------
`default_nettype none

package wfhv_pkg;

  localparam int LENGTH_BITS = 13;
  localparam int TOTAL_W     = 13;
  localparam int MAX_LEN_W   = 13;
  localparam int CMP_W       = (LENGTH_BITS > MAX_LEN_W) ? LENGTH_BITS : MAX_LEN_W;
  localparam int FLAGS_W     = 17;

  localparam logic [LENGTH_BITS-1:0] COUNT_TOP = {LENGTH_BITS{1'b1}};

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam logic           CFG_IDX_MAX_LEN = 1'b0;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = MAX_LEN_W'(2346);

  localparam logic [2:0] VERDICT_OK       = 3'd0;
  localparam logic [2:0] VERDICT_OVERSIZE = 3'd1;
  localparam logic [2:0] VERDICT_RUNT     = 3'd2;
  localparam logic [2:0] VERDICT_VERSION  = 3'd3;
  localparam logic [2:0] VERDICT_RSVD     = 3'd4;
  localparam logic [2:0] VERDICT_SHORT    = 3'd5;

  localparam logic [1:0] KIND_MGMT = 2'd0;
  localparam logic [1:0] KIND_CTRL = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;
  localparam logic [1:0] KIND_RSVD = 2'd3;

  localparam logic [3:0] MST_ASSOC_REQ    = 4'd0;
  localparam logic [3:0] MST_ASSOC_RESP   = 4'd1;
  localparam logic [3:0] MST_REASSOC_REQ  = 4'd2;
  localparam logic [3:0] MST_REASSOC_RESP = 4'd3;
  localparam logic [3:0] MST_PROBE_REQ    = 4'd4;
  localparam logic [3:0] MST_PROBE_RESP   = 4'd5;
  localparam logic [3:0] MST_BEACON       = 4'd8;
  localparam logic [3:0] MST_ATIM         = 4'd9;
  localparam logic [3:0] MST_DISASSOC     = 4'd10;
  localparam logic [3:0] MST_AUTH         = 4'd11;
  localparam logic [3:0] MST_DEAUTH       = 4'd12;
  localparam logic [3:0] MST_ACTION       = 4'd13;

  localparam logic [3:0] CST_BAR         = 4'd8;
  localparam logic [3:0] CST_BA          = 4'd9;
  localparam logic [3:0] CST_RTS         = 4'd11;
  localparam logic [3:0] CST_CTS         = 4'd12;
  localparam logic [3:0] CST_ACK         = 4'd13;
  localparam logic [3:0] CST_CF_END      = 4'd14;
  localparam logic [3:0] CST_CF_END_ACK  = 4'd15;

  localparam int FLG_BCN_INT      = 0;
  localparam int FLG_AUTH_ALG     = 1;
  localparam int FLG_AUTH_SEQ     = 2;
  localparam int FLG_REASON       = 3;
  localparam int FLG_LISTEN       = 4;
  localparam int FLG_AID          = 5;
  localparam int FLG_ACT_CAT      = 6;
  localparam int FLG_MGMT_ST      = 7;
  localparam int FLG_MGMT_DS      = 8;
  localparam int FLG_RTS_DUR      = 9;
  localparam int FLG_CTS_DUR      = 10;
  localparam int FLG_CTRL_ST      = 11;
  localparam int FLG_CTRL_DS      = 12;
  localparam int FLG_CTRL_RTY     = 13;
  localparam int FLG_NO_PAYLOAD   = 14;
  localparam int FLG_NULL_PAYLOAD = 15;
  localparam int FLG_FRAG         = 16;

  typedef struct packed {
    logic [LENGTH_BITS-1:0] len;
    logic [7:0]             fc0;
    logic [7:0]             fc1;
    logic [15:0]            dur;
    logic [15:0]            seq;
    logic [3:0][15:0]       body;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

`default_nettype wire

### rtl/wfhv_front.sv
// ----------------------------------------------------------------------------
// wfhv_front: byte capture
// Counts frame bytes and captures the header words; on the last byte it
// pushes one frame record into the queue and clears for the next frame.
// ----------------------------------------------------------------------------
`default_nettype none

module wfhv_front (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  input  wire  [7:0]               in_data_byte,
  input  wire                      in_last_byte,
  output logic                     in_stall,
  input  wfhv_pkg::queue_stat_t    q_stat,
  output logic                     push,
  output wfhv_pkg::frame_rec_t     push_rec
);
  import wfhv_pkg::*;

  frame_rec_t cur_r;
  frame_rec_t cur_nxt;
  logic       accept;

  function automatic logic [15:0] put_word(input logic [15:0] w,
                                           input logic [LENGTH_BITS-1:0] pos,
                                           input logic [LENGTH_BITS-1:0] base,
                                           input logic [7:0] b);
    logic [15:0] r;
    r = w;
    if (pos == base) begin
      r[7:0] = b;
    end else if (pos == base + LENGTH_BITS'(1)) begin
      r[15:8] = b;
    end
    return r;
  endfunction

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && in_last_byte;

  always_comb begin
    push_rec = cur_r;
    if (cur_r.len == LENGTH_BITS'(0)) begin
      push_rec.fc0 = in_data_byte;
    end
    if (cur_r.len == LENGTH_BITS'(1)) begin
      push_rec.fc1 = in_data_byte;
    end
    push_rec.dur     = put_word(cur_r.dur, cur_r.len, LENGTH_BITS'(2), in_data_byte);
    push_rec.seq     = put_word(cur_r.seq, cur_r.len, LENGTH_BITS'(22), in_data_byte);
    push_rec.body[0] = put_word(cur_r.body[0], cur_r.len, LENGTH_BITS'(24), in_data_byte);
    push_rec.body[1] = put_word(cur_r.body[1], cur_r.len, LENGTH_BITS'(26), in_data_byte);
    push_rec.body[2] = put_word(cur_r.body[2], cur_r.len, LENGTH_BITS'(28), in_data_byte);
    push_rec.body[3] = put_word(cur_r.body[3], cur_r.len, LENGTH_BITS'(32), in_data_byte);
    if (cur_r.len != COUNT_TOP) begin
      push_rec.len = cur_r.len + LENGTH_BITS'(1);
    end
  end

  always_comb begin
    cur_nxt = cur_r;
    if (accept) begin
      if (in_last_byte) begin
        cur_nxt = '0;
      end else begin
        cur_nxt = push_rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
    end else begin
      cur_r <= cur_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/wfhv_queue.sv
// ----------------------------------------------------------------------------
// wfhv_queue: frame record queue
// A short register queue between capture and checking, so that a stalled
// result side does not stop byte intake until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module wfhv_queue (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      push,
  input  wfhv_pkg::frame_rec_t     push_rec,
  input  wire                      pop,
  output wfhv_pkg::frame_rec_t     head_rec,
  output wfhv_pkg::queue_stat_t    q_stat
);
  import wfhv_pkg::*;

  frame_rec_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign head_rec     = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? bump(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

`default_nettype wire

### rtl/wfhv_back.sv
// ----------------------------------------------------------------------------
// wfhv_back: frame checks
// Takes a frame record from the queue, runs the length, version, type and
// subtype checks and the warning checks, and holds the verdict in the
// output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module wfhv_back (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wfhv_pkg::frame_rec_t           head_rec,
  input  wfhv_pkg::queue_stat_t          q_stat,
  output logic                           pop,
  input  wire  [wfhv_pkg::MAX_LEN_W-1:0] max_frame_len,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [2:0]                     out_verdict,
  output logic [1:0]                     out_frame_kind,
  output logic [3:0]                     out_frame_subkind,
  output logic [wfhv_pkg::TOTAL_W-1:0]   out_byte_total,
  output logic [wfhv_pkg::FLAGS_W-1:0]   out_warning_flags
);
  import wfhv_pkg::*;

  logic                   out_valid_r, out_valid_nxt;
  logic [2:0]             verdict_r;
  logic [1:0]             kind_r;
  logic [3:0]             subkind_r;
  logic [TOTAL_W-1:0]     total_r;
  logic [FLAGS_W-1:0]     flags_r;

  logic [1:0]             kind;
  logic [3:0]             st;
  logic [7:0]             fc1;
  logic [LENGTH_BITS-1:0] len;
  logic [5:0]             min_len;
  logic [5:0]             dmin;
  logic [2:0]             verdict;
  logic [FLAGS_W-1:0]     flags;
  logic [7:0]             cat;

  function automatic logic [5:0] mgmt_min(input logic [3:0] s);
    logic [5:0] m;
    unique case (s)
      MST_ASSOC_REQ, MST_REASSOC_REQ:                m = 6'd28;
      MST_ASSOC_RESP, MST_REASSOC_RESP, MST_AUTH:    m = 6'd30;
      MST_PROBE_RESP, MST_BEACON:                    m = 6'd36;
      MST_DISASSOC, MST_DEAUTH, MST_ACTION:          m = 6'd26;
      default:                                       m = 6'd24;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] ctrl_min(input logic [3:0] s);
    logic [5:0] m;
    unique case (s)
      CST_RTS, CST_CF_END, CST_CF_END_ACK: m = 6'd16;
      CST_BAR:                             m = 6'd20;
      CST_BA:                              m = 6'd24;
      default:                             m = 6'd10;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] data_min(input logic [3:0] s, input logic [7:0] f1);
    logic [5:0] m;
    m = 6'd24;
    if (s[3]) begin
      m = m + 6'd2;
    end
    if (f1[1:0] == 2'b11) begin
      m = m + 6'd6;
    end
    if (s[3] && f1[7]) begin
      m = m + 6'd4;
    end
    return m;
  endfunction

  assign kind = head_rec.fc0[3:2];
  assign st   = head_rec.fc0[7:4];
  assign fc1  = head_rec.fc1;
  assign len  = head_rec.len;
  assign dmin = data_min(st, fc1);
  assign cat  = head_rec.body[0][7:0];

  always_comb begin
    unique case (kind)
      KIND_MGMT: min_len = mgmt_min(st);
      KIND_CTRL: min_len = ctrl_min(st);
      default:   min_len = dmin;
    endcase
  end

  always_comb begin
    priority if (CMP_W'(len) > CMP_W'(max_frame_len)) begin
      verdict = VERDICT_OVERSIZE;
    end else if (len < LENGTH_BITS'(10)) begin
      verdict = VERDICT_RUNT;
    end else if (head_rec.fc0[1:0] != 2'b00) begin
      verdict = VERDICT_VERSION;
    end else if (kind == KIND_RSVD) begin
      verdict = VERDICT_RSVD;
    end else if (len < LENGTH_BITS'(min_len)) begin
      verdict = VERDICT_SHORT;
    end else begin
      verdict = VERDICT_OK;
    end
  end

  always_comb begin
    flags = '0;
    unique case (kind)
      KIND_MGMT: begin
        unique case (st)
          MST_PROBE_RESP, MST_BEACON: begin
            flags[FLG_BCN_INT] = (head_rec.body[3] == 16'd0);
          end
          MST_AUTH: begin
            flags[FLG_AUTH_ALG] = (head_rec.body[0] > 16'd3);
            flags[FLG_AUTH_SEQ] = (head_rec.body[1] == 16'd0) || (head_rec.body[1] > 16'd4);
          end
          MST_DISASSOC, MST_DEAUTH: begin
            flags[FLG_REASON] = (head_rec.body[0] == 16'd0) || (head_rec.body[0] > 16'd65);
          end
          MST_ASSOC_REQ, MST_REASSOC_REQ: begin
            flags[FLG_LISTEN] = (head_rec.body[1] == 16'd0);
          end
          MST_ASSOC_RESP, MST_REASSOC_RESP: begin
            flags[FLG_AID] = (head_rec.body[2][15:14] != 2'b11);
          end
          MST_ACTION: begin
            flags[FLG_ACT_CAT] = (cat > 8'd127) && (cat < 8'd221);
          end
          MST_PROBE_REQ, MST_ATIM: begin
          end
          default: begin
            flags[FLG_MGMT_ST] = 1'b1;
          end
        endcase
        flags[FLG_MGMT_DS] = (fc1[1:0] != 2'b00);
      end
      KIND_CTRL: begin
        unique case (st)
          CST_RTS: begin
            flags[FLG_RTS_DUR] = (head_rec.dur == 16'd0) || head_rec.dur[15];
          end
          CST_CTS: begin
            flags[FLG_CTS_DUR] = head_rec.dur[15];
          end
          CST_BAR, CST_BA, CST_ACK, CST_CF_END, CST_CF_END_ACK: begin
          end
          default: begin
            flags[FLG_CTRL_ST] = 1'b1;
          end
        endcase
        flags[FLG_CTRL_DS]  = (fc1[1:0] != 2'b00);
        flags[FLG_CTRL_RTY] = (fc1[3:2] != 2'b00);
      end
      default: begin
        if (!st[2]) begin
          flags[FLG_NO_PAYLOAD] = (len <= LENGTH_BITS'(dmin));
        end else begin
          flags[FLG_NULL_PAYLOAD] = (len > LENGTH_BITS'(dmin));
        end
        flags[FLG_FRAG] = (head_rec.seq[3:0] != 4'd0) && !fc1[2];
      end
    endcase
    if (verdict != VERDICT_OK) begin
      flags = '0;
    end
  end

  assign pop = !q_stat.empty && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      verdict_r <= verdict;
      kind_r    <= kind;
      subkind_r <= st;
      total_r   <= TOTAL_W'(len);
      flags_r   <= flags;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_verdict       = verdict_r;
  assign out_frame_kind    = kind_r;
  assign out_frame_subkind = subkind_r;
  assign out_byte_total    = total_r;
  assign out_warning_flags = flags_r;

endmodule

`default_nettype wire

### rtl/wifi_frame_header_validator_top.sv
// ----------------------------------------------------------------------------
// wifi_frame_header_validator_top: 802.11 MAC header checker
// Frame bytes come in one per transfer; one verdict transfer leaves per
// frame. Holds the maximum frame length register behind an APB port.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                     Moves
//   input     in_valid/in_stall, in_data_byte,          one frame byte
//             in_last_byte
//   result    out_valid/out_stall, out_verdict, ...     one verdict per frame
//   config    psel/penable/pwrite/paddr/pwdata/prdata   max_frame_len at 0x0
//
// One byte is taken every cycle while in_stall is low. A verdict is valid once
// the frame's record is popped from the queue while the result side is free.
// Up to four finished frames wait in the queue; with it full, in_stall rises.
// Reset is synchronous and active low; it clears the capture state, the queue
// and the output valid, and sets max_frame_len to 2346.
// ----------------------------------------------------------------------------
`default_nettype none

module wifi_frame_header_validator_top (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [7:0]                       in_data_byte,
  input  wire                              in_last_byte,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [2:0]                       out_verdict,
  output logic [1:0]                       out_frame_kind,
  output logic [3:0]                       out_frame_subkind,
  output logic [wfhv_pkg::TOTAL_W-1:0]     out_byte_total,
  output logic [wfhv_pkg::FLAGS_W-1:0]     out_warning_flags,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [wfhv_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire  [wfhv_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [wfhv_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import wfhv_pkg::*;

  logic [MAX_LEN_W-1:0] max_len_r, max_len_nxt;
  logic                 cfg_wr;
  logic                 cfg_idx;
  logic                 push;
  logic                 pop;
  frame_rec_t           push_rec;
  frame_rec_t           head_rec;
  queue_stat_t          q_stat;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    max_len_nxt = max_len_r;
    if (cfg_wr && (cfg_idx == CFG_IDX_MAX_LEN)) begin
      max_len_nxt = pwdata[MAX_LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  assign prdata = (cfg_idx == CFG_IDX_MAX_LEN) ? APB_DATA_W'(max_len_r) : '0;

  wfhv_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .in_stall     (in_stall),
    .q_stat       (q_stat),
    .push         (push),
    .push_rec     (push_rec)
  );

  wfhv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .q_stat   (q_stat)
  );

  wfhv_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_rec          (head_rec),
    .q_stat            (q_stat),
    .pop               (pop),
    .max_frame_len     (max_len_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_verdict       (out_verdict),
    .out_frame_kind    (out_frame_kind),
    .out_frame_subkind (out_frame_subkind),
    .out_byte_total    (out_byte_total),
    .out_warning_flags (out_warning_flags)
  );

  a_flags_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_verdict != VERDICT_OK)) |-> (out_warning_flags == '0))
    else $error("warning flags set on a rejected frame");

  a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push)
    else $error("frame record pushed into a full queue");

  a_pop_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid)
    else $error("popped frame record did not reach the output register");

endmodule

`default_nettype wire
